// ===== hdl/plf_pkg.sv =====
package plf_pkg;

  // Line buffer geometry
  localparam int LineCapacity = 63;
  localparam int AddrW        = $clog2(LineCapacity);
  localparam int CountW       = $clog2(LineCapacity + 1);

  // Stream constants
  localparam logic [7:0] NewlineByte = 8'd10;
  localparam int         ComplexMin  = 3;

  // Configuration port geometry
  localparam int PaddrW = 5;
  localparam int PdataW = 32;

  typedef enum logic [2:0] {
    RegMinLength   = 3'd0,
    RegMaxLength   = 3'd1,
    RegLowestByte  = 3'd2,
    RegHighestByte = 3'd3,
    RegKeepComplex = 3'd4,
    RegKeepSimple  = 3'd5
  } plf_reg_e;

  // Reset values of the configuration registers
  localparam logic [5:0] MinLengthRst   = 6'd0;
  localparam logic [5:0] MaxLengthRst   = 6'd63;
  localparam logic [7:0] LowestByteRst  = 8'd32;
  localparam logic [7:0] HighestByteRst = 8'd126;

  typedef enum logic {
    StIdle,
    StEmit
  } plf_state_e;

  typedef struct packed {
    logic [5:0] min_length;
    logic [5:0] max_length;
    logic [7:0] lowest_byte;
    logic [7:0] highest_byte;
    logic       keep_complex;
    logic       keep_simple;
  } plf_cfg_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } plf_ram_req_t;

  // Class bits: [0] upper, [1] lower, [2] digit, [3] printable special
  function automatic logic [3:0] byte_class(input logic [7:0] b);
    logic [3:0] c;
    c = 4'b0000;
    if (b inside {[8'd65:8'd90]}) begin
      c = 4'b0001;
    end else if (b inside {[8'd97:8'd122]}) begin
      c = 4'b0010;
    end else if (b inside {[8'd48:8'd57]}) begin
      c = 4'b0100;
    end else if (b inside {[8'd32:8'd47], [8'd58:8'd64], [8'd91:8'd96],
                           [8'd123:8'd126]}) begin
      c = 4'b1000;
    end
    return c;
  endfunction

endpackage

// ===== hdl/plf_if.sv =====
// Input byte stream channel
interface plf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

// Filtered line output channel
interface plf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/password_line_filter.sv =====
// Password line filter.
// in_i carries a byte stream (data_byte, end_of_input); words are separated by
// newline bytes. out_o carries the bytes of each kept line followed by a
// newline with last set. Both are valid/ready channels; a transfer happens on
// a rising edge with valid and ready high. Limits, byte range and keep flags
// are set through the APB port (registers at byte addresses 0, 4, ... 20);
// the user must see that they are written only while the block is idle, as
// the block itself does not enforce it. A non-newline byte goes to the line
// RAM unless it is out of range, the line is full or the line is skipped.
// A newline that keeps its line switches to emission: the line is read back
// through the single RAM read port at one byte per cycle while out_o is
// ready, and input is held off meanwhile. The output register decouples the
// receiver: a stalled out_o holds the current byte, stops RAM reads and, once
// the line is done, lets input resume.
// Reset clears the line count, skip flag, class bits and the output channel
// and loads the register defaults; RAM contents are left as they are.
module password_line_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  plf_in_if.sink                     in_i,
  plf_out_if.source                  out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plf_pkg::PaddrW-1:0] paddr,
  input  logic [plf_pkg::PdataW-1:0] pwdata,
  output logic [plf_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import plf_pkg::*;

  plf_cfg_t     cfg;
  plf_ram_req_t ram_req;
  logic [7:0]   ram_rd_data;

  plf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plf_line_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

  plf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_i          (in_i),
    .out_o         (out_o),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  // RAM is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("line RAM write and read overlap");

  // Reads only happen while input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.re |-> !in_i.ready)
    else $error("RAM read while input is open");

  // Writes stay inside the line buffer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (ram_req.waddr < AddrW'(LineCapacity)))
    else $error("line RAM write out of range");

  // A line end is always the newline byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.out_byte == NewlineByte))
    else $error("last set on a non-newline byte");

endmodule

// ===== hdl/plf_line_ram.sv =====
module plf_line_ram (
  input  logic                  clk_i,
  input  plf_pkg::plf_ram_req_t req_i,
  output logic [7:0]            rd_data_o
);
  import plf_pkg::*;

  logic [7:0] mem [LineCapacity];

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_o <= mem[req_i.raddr];
    end
  end

endmodule

// ===== hdl/plf_regs.sv =====
module plf_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [plf_pkg::PaddrW-1:0] paddr,
  input  logic [plf_pkg::PdataW-1:0] pwdata,
  output logic [plf_pkg::PdataW-1:0] prdata,
  output logic                      pready,
  output plf_pkg::plf_cfg_t         cfg_o
);
  import plf_pkg::*;

  plf_cfg_t   cfg_q, cfg_d;
  logic       wr_en;
  plf_reg_e   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = plf_reg_e'(paddr[PaddrW-1:2]);
  assign cfg_o   = cfg_q;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        RegMinLength:   cfg_d.min_length   = pwdata[5:0];
        RegMaxLength:   cfg_d.max_length   = pwdata[5:0];
        RegLowestByte:  cfg_d.lowest_byte  = pwdata[7:0];
        RegHighestByte: cfg_d.highest_byte = pwdata[7:0];
        RegKeepComplex: cfg_d.keep_complex = pwdata[0];
        RegKeepSimple:  cfg_d.keep_simple  = pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_sel)
      RegMinLength:   prdata = PdataW'(cfg_q.min_length);
      RegMaxLength:   prdata = PdataW'(cfg_q.max_length);
      RegLowestByte:  prdata = PdataW'(cfg_q.lowest_byte);
      RegHighestByte: prdata = PdataW'(cfg_q.highest_byte);
      RegKeepComplex: prdata = PdataW'(cfg_q.keep_complex);
      RegKeepSimple:  prdata = PdataW'(cfg_q.keep_simple);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_length   <= MinLengthRst;
      cfg_q.max_length   <= MaxLengthRst;
      cfg_q.lowest_byte  <= LowestByteRst;
      cfg_q.highest_byte <= HighestByteRst;
      cfg_q.keep_complex <= 1'b0;
      cfg_q.keep_simple  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/plf_ctrl.sv =====
module plf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  plf_pkg::plf_cfg_t     cfg_i,
  plf_in_if.sink                in_i,
  plf_out_if.source             out_o,
  output plf_pkg::plf_ram_req_t ram_req_o,
  input  logic [7:0]            ram_rd_data_i
);
  import plf_pkg::*;

  plf_state_e        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [3:0]        class_q, class_d;
  logic              skip_q, skip_d;
  logic              rd_pend_q, rd_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic in_xfer;
  logic in_range;
  logic has_room;
  logic len_ok;
  logic rule_met;
  logic keep;
  logic load_ok;

  assign in_i.ready   = (state_q == StIdle);
  assign in_xfer      = in_i.valid && in_i.ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last   = out_last_q;

  // Line checks
  assign in_range   = (in_i.data_byte >= cfg_i.lowest_byte) &&
                      (in_i.data_byte <= cfg_i.highest_byte);
  assign has_room   = count_q < CountW'(LineCapacity);
  assign len_ok     = (count_q >= CountW'(cfg_i.min_length)) &&
                      (count_q <= CountW'(cfg_i.max_length));
  assign rule_met   = $countones(class_q) >= ComplexMin;
  assign keep       = (cfg_i.keep_complex && rule_met) ||
                      (cfg_i.keep_simple && !rule_met) ||
                      (!cfg_i.keep_complex && !cfg_i.keep_simple);
  // Output register free or being drained this cycle
  assign load_ok    = !out_valid_q || out_o.ready;

  // Next state: store bytes while idle, stream the line out while emitting
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    class_d     = class_q;
    skip_d      = skip_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    ram_req_o   = '0;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_i.end_of_input) begin
            count_d = '0;
            class_d = '0;
            skip_d  = 1'b0;
          end else if (in_i.data_byte != NewlineByte) begin
            if (!skip_q) begin
              if (in_range && has_room) begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = count_q[AddrW-1:0];
                ram_req_o.wdata = in_i.data_byte;
                count_d         = count_q + 1'b1;
                class_d         = class_q | byte_class(in_i.data_byte);
              end else begin
                count_d = '0;
                class_d = '0;
                skip_d  = 1'b1;
              end
            end
          end else if (skip_q) begin
            skip_d  = 1'b0;
            count_d = '0;
            class_d = '0;
          end else if (len_ok && keep) begin
            state_d   = StEmit;
            idx_d     = '0;
            rd_pend_d = 1'b0;
          end else begin
            count_d = '0;
            class_d = '0;
          end
        end
      end

      StEmit: begin
        // Move read data into the output register
        if (rd_pend_q && load_ok) begin
          out_valid_d = 1'b1;
          out_byte_d  = ram_rd_data_i;
          out_last_d  = 1'b0;
          rd_pend_d   = 1'b0;
        end
        if ((!rd_pend_q || load_ok) && (idx_q < count_q)) begin
          // Issue next read
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_q[AddrW-1:0];
          idx_d           = idx_q + 1'b1;
          rd_pend_d       = 1'b1;
        end else if (!rd_pend_q && load_ok) begin
          // Closing newline ends the line
          out_valid_d = 1'b1;
          out_byte_d  = NewlineByte;
          out_last_d  = 1'b1;
          count_d     = '0;
          class_d     = '0;
          state_d     = StIdle;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      class_q     <= '0;
      skip_q      <= 1'b0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      class_q     <= class_d;
      skip_q      <= skip_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

endmodule
